[design/lsae_pkg.sv]
// ----------------------------------------------------------------------------
// lsae_pkg
// Shared constants and helpers for the light sensor angle estimator.
// ----------------------------------------------------------------------------
package lsae_pkg;

  // Default sample width of the converter
  localparam int SAMPLE_BITS_DEF = 10;

  // Sector width register
  localparam int         WIDTH_BITS  = 7;
  localparam logic [6:0] WIDTH_RESET = 7'd50;

  // Offset quotient never exceeds ceil(127/2), so seven bits carry it
  localparam int QUO_BITS   = 7;
  localparam int ANGLE_BITS = 8;

  // Configuration port
  localparam int         CFG_ADDR_BITS    = 3;
  localparam int         CFG_DATA_BITS    = 32;
  localparam logic [0:0] REG_SECTOR_WIDTH = 1'b0;

  // Sensor index codes
  localparam logic [1:0] SENSOR_0 = 2'd0;
  localparam logic [1:0] SENSOR_1 = 2'd1;
  localparam logic [1:0] SENSOR_2 = 2'd2;
  localparam logic [1:0] SENSOR_3 = 2'd3;

  // Base angle of each sensor in degrees
  function automatic logic [ANGLE_BITS-1:0] base_angle(input logic [1:0] idx);
    logic [ANGLE_BITS-1:0] a;
    case (idx)
      SENSOR_0: a = 8'd15;
      SENSOR_1: a = 8'd65;
      SENSOR_2: a = 8'd115;
      SENSOR_3: a = 8'd165;
      default:  a = 8'd15;
    endcase
    return a;
  endfunction

endpackage

[design/light_sensor_angle_estimator.sv]
// ----------------------------------------------------------------------------
// light_sensor_angle_estimator
// Picks the brightest of four light sensors and its brighter neighbour, then
// interpolates the optimum angle with a pipelined restoring divider.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid, in_stall     | in_sample_zero/one/two/three
//  out     | out_valid, out_stall   | out_angle, out_brightest, out_dark
//  config  | psel, penable, pready  | pwrite, paddr, pwdata, prdata
//
// The pipeline has three front stages (capture, peak and neighbour select,
// sums), one multiply stage, one divider stage per quotient bit and the
// output register. One item enters every cycle while in_stall is low.
// Each stage holds while the next one is full and held; empty stages fill,
// so bubbles squeeze out. Reset clears all valid bits and loads sector_width
// with 50.
module light_sensor_angle_estimator #(
  parameter int SAMPLE_BITS = lsae_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [SAMPLE_BITS-1:0]              in_sample_zero,
  input  logic [SAMPLE_BITS-1:0]              in_sample_one,
  input  logic [SAMPLE_BITS-1:0]              in_sample_two,
  input  logic [SAMPLE_BITS-1:0]              in_sample_three,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lsae_pkg::ANGLE_BITS-1:0]     out_angle,
  output logic [1:0]                          out_brightest,
  output logic                                out_dark,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsae_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [lsae_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [lsae_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import lsae_pkg::*;

  localparam int QB = QUO_BITS;
  localparam int SW = SAMPLE_BITS + 2;           // a1 + 2*a2
  localparam int DW = SAMPLE_BITS + 3;           // 3*(a1 + a2)
  localparam int NW = SAMPLE_BITS + WIDTH_BITS + 3; // dividend with rounding

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] den;
    logic [QB-1:0] quo;
    logic [1:0]    best;
    logic          upward;
    logic          dark;
  } div_t;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [WIDTH_BITS-1:0] width_r;
  logic                  cfg_hit;

  assign cfg_hit = (paddr[CFG_ADDR_BITS-1:2] == REG_SECTOR_WIDTH);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? CFG_DATA_BITS'(width_r) : '0;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      width_r <= pwdata[WIDTH_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake
  // --------------------------------------------------------------------------
  logic          s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic [QB:0]   dv_vld_r;
  logic          s1_rdy, s2_rdy, s3_rdy, out_rdy;
  logic [QB:0]   dv_rdy;

  assign out_rdy = !out_vld_r || !out_stall;
  assign dv_rdy[QB] = !dv_vld_r[QB] || out_rdy;
  for (genvar k = 0; k < QB; k++) begin : g_rdy
    assign dv_rdy[k] = !dv_vld_r[k] || dv_rdy[k+1];
  end
  assign s3_rdy   = !s3_vld_r || dv_rdy[0];
  assign s2_rdy   = !s2_vld_r || s3_rdy;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign in_stall = !s1_rdy;

  // --------------------------------------------------------------------------
  // Stage 1: capture samples
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] smp_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      smp_r[0] <= in_sample_zero;
      smp_r[1] <= in_sample_one;
      smp_r[2] <= in_sample_two;
      smp_r[3] <= in_sample_three;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: brightest sensor and neighbour
  // --------------------------------------------------------------------------
  logic [1:0]             best_nxt, nb_nxt;
  logic [SAMPLE_BITS-1:0] peak_nxt;
  logic [SAMPLE_BITS-1:0] a1_r, a2_r;
  logic [1:0]             best_s2_r;
  logic                   up_s2_r;

  always_comb begin
    // first strictly greater sample wins
    best_nxt = SENSOR_0;
    peak_nxt = smp_r[0];
    if (smp_r[1] > peak_nxt) begin
      best_nxt = SENSOR_1;
      peak_nxt = smp_r[1];
    end
    if (smp_r[2] > peak_nxt) begin
      best_nxt = SENSOR_2;
      peak_nxt = smp_r[2];
    end
    if (smp_r[3] > peak_nxt) begin
      best_nxt = SENSOR_3;
      peak_nxt = smp_r[3];
    end
    // end sensors have one neighbour; inner ties go upward
    case (best_nxt)
      SENSOR_0: nb_nxt = SENSOR_1;
      SENSOR_3: nb_nxt = SENSOR_2;
      SENSOR_1: nb_nxt = (smp_r[0] > smp_r[2]) ? SENSOR_0 : SENSOR_2;
      SENSOR_2: nb_nxt = (smp_r[1] > smp_r[3]) ? SENSOR_1 : SENSOR_3;
      default:  nb_nxt = SENSOR_1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      a1_r      <= peak_nxt;
      a2_r      <= smp_r[nb_nxt];
      best_s2_r <= best_nxt;
      up_s2_r   <= (nb_nxt > best_nxt);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: numerator sum and denominator
  // --------------------------------------------------------------------------
  logic [SW-1:0] sum12_nxt;
  logic [DW-1:0] pair_nxt, den_nxt;
  logic [SW-1:0] sum12_r;
  logic [DW-1:0] den_r;
  logic [1:0]    best_s3_r;
  logic          up_s3_r;

  always_comb begin
    sum12_nxt = SW'(a1_r) + {1'b0, a2_r, 1'b0};
    pair_nxt  = DW'(a1_r) + DW'(a2_r);
    den_nxt   = pair_nxt + {pair_nxt[DW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_vld_r) begin
      sum12_r   <= sum12_nxt;
      den_r     <= den_nxt;
      best_s3_r <= best_s2_r;
      up_s3_r   <= up_s2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: scale by sector width, round toward the lower side
  // --------------------------------------------------------------------------
  div_t          dv_r   [QB+1];
  div_t          dv_nxt [QB+1];
  logic [NW-1:0] num_nxt;

  always_comb begin
    num_nxt       = NW'(width_r) * NW'(sum12_r);
    dv_nxt[0]     = '0;
    dv_nxt[0].den = den_r;
    dv_nxt[0].best   = best_s3_r;
    dv_nxt[0].upward = up_s3_r;
    dv_nxt[0].dark   = (den_r == '0);
    if (den_r == '0) begin
      dv_nxt[0].rem = '0;
    end else if (up_s3_r) begin
      dv_nxt[0].rem = num_nxt;
    end else begin
      dv_nxt[0].rem = num_nxt + NW'(den_r) - NW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage, most significant first
  // --------------------------------------------------------------------------
  for (genvar j = 0; j <= QB; j++) begin : g_div
    if (j > 0) begin : g_step
      localparam int B = QB - j;
      logic [NW-1:0] shd;

      always_comb begin
        shd       = NW'(dv_r[j-1].den) << B;
        dv_nxt[j] = dv_r[j-1];
        if (dv_r[j-1].rem >= shd) begin
          dv_nxt[j].rem    = dv_r[j-1].rem - shd;
          dv_nxt[j].quo[B] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_vld_r[j] <= 1'b0;
        end else if (dv_rdy[j]) begin
          dv_vld_r[j] <= dv_vld_r[j-1];
        end
      end

      always_ff @(posedge clk) begin
        if (dv_rdy[j] && dv_vld_r[j-1]) begin
          dv_r[j] <= dv_nxt[j];
        end
      end
    end else begin : g_load
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_vld_r[0] <= 1'b0;
        end else if (dv_rdy[0]) begin
          dv_vld_r[0] <= s3_vld_r;
        end
      end

      always_ff @(posedge clk) begin
        if (dv_rdy[0] && s3_vld_r) begin
          dv_r[0] <= dv_nxt[0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: apply offset to base angle
  // --------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] base_nxt, angle_nxt;
  logic [ANGLE_BITS-1:0] angle_r;
  logic [1:0]            best_out_r;
  logic                  dark_out_r;

  always_comb begin
    base_nxt = base_angle(dv_r[QB].best);
    if (dv_r[QB].dark) begin
      angle_nxt = base_nxt;
    end else if (dv_r[QB].upward) begin
      angle_nxt = base_nxt + ANGLE_BITS'(dv_r[QB].quo);
    end else begin
      angle_nxt = base_nxt - ANGLE_BITS'(dv_r[QB].quo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= dv_vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && dv_vld_r[QB]) begin
      angle_r    <= angle_nxt;
      best_out_r <= dv_r[QB].best;
      dark_out_r <= dv_r[QB].dark;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_angle     = angle_r;
  assign out_brightest = best_out_r;
  assign out_dark      = dark_out_r;

endmodule
